// ===== src/kfli_pkg.sv =====
`default_nettype none
package kfli_pkg;

	localparam int MaxFrames = 256;
	localparam int MaxDof = 16;
	localparam int FrameAw = $clog2(MaxFrames);
	localparam int DofAw = $clog2(MaxDof);
	localparam int CoordAw = FrameAw + DofAw;
	localparam int CountW = FrameAw + 1;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_DOF = 3'd1,
		ST_ORDER = 3'd2,
		ST_FULL = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// divider handshake
	typedef struct packed {
		logic start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [16:0] quot;
	} div_rsp_t;

endpackage
`default_nettype wire

// ===== src/kfli_divider.sv =====
`default_nettype none
// Restoring divider: quot = floor((num << 16) / den), num < den, one bit a cycle.
module kfli_divider (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire kfli_pkg::div_req_t  req,
	output kfli_pkg::div_rsp_t       rsp
);
	import kfli_pkg::*;

	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [16:0] quot_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] shl;
	logic [33:0] diff;

	assign shl  = {rem_q, 1'b0};
	assign diff = shl - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
				rem_q  <= {1'b0, req.num};
				den_q  <= req.den;
				quot_q <= '0;
			end else if (busy_q) begin
				if (!diff[33]) begin
					rem_q  <= diff[32:0];
					quot_q <= {quot_q[15:0], 1'b1};
				end else begin
					rem_q  <= shl[32:0];
					quot_q <= {quot_q[15:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

`ifndef SYNTH
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(busy_q)) else $error("done without busy");
	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> !rsp.quot[16]) else $error("quotient overflow");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start |=> busy_q || done_q) else $error("divider dropped");
`endif
endmodule
`default_nettype wire

// ===== src/keyframe_linear_interpolator_top.sv =====
`default_nettype none
// Add item: the status result is strobed from S_ADDFIN (none for an inner coordinate).
// Query: stored times are searched in S_SRCH_RD/S_SRCH_CMP, the divide runs on a hit,
// then each coordinate passes S_RDA to S_LASTEMIT; with no hit, the last frame is emitted.
// Busy is high throughout.
// Results are strobed for one cycle; the receiver cannot stall.
// Asynchronous active-low reset clears counts, dof_count to 1 and control state.
module keyframe_linear_interpolator_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire logic         op,
	input  wire logic [31:0]  time_req,
	input  wire logic signed [31:0] value,
	input  wire logic         frame_end,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [4:0]   cfg_data,
	output logic              strobe,
	output logic [2:0]        status,
	output logic [3:0]        coord_index,
	output logic signed [31:0] result_value,
	output logic              last
);
	import kfli_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_ADDCHK, S_ADDFIN, S_SRCH_RD, S_SRCH_CMP, S_DIV, S_RDA, S_RDB,
		S_MUL, S_EMIT, S_LASTRD, S_LASTEMIT
	} state_t;

	state_t state_q;

	// memories: time stamps and coordinates, registered reads
	logic [31:0] times_mem [MaxFrames];
	logic [31:0] coord_mem [MaxFrames*MaxDof];
	logic [FrameAw-1:0] t_raddr;
	logic [31:0] t_rdata_q;
	logic [CoordAw-1:0] c_raddr;
	logic [31:0] c_rdata_q;
	logic t_we, c_we;
	logic [FrameAw-1:0] t_waddr;
	logic [CoordAw-1:0] c_waddr;
	logic [31:0] t_wdata, c_wdata;

	always_ff @(posedge clk) begin
		if (t_we) times_mem[t_waddr] <= t_wdata;
		t_rdata_q <= times_mem[t_raddr];
	end
	always_ff @(posedge clk) begin
		if (c_we) coord_mem[c_waddr] <= c_wdata;
		c_rdata_q <= coord_mem[c_raddr];
	end

	logic [4:0]  dof_q;
	logic [CountW-1:0] count_q;
	logic [4:0]  pend_q;
	logic [31:0] ptime_q;
	logic [31:0] lastt_q;      // time of the last stored frame
	logic [31:0] qt_q;         // query time
	logic [FrameAw-1:0] idx_q; // search index
	logic [31:0] t0_q;
	logic [FrameAw-1:0] seg_q;
	logic [16:0] frac_q;
	logic [4:0]  ci_q;
	logic [4:0]  n_q;
	logic signed [32:0] a_q, diffv_q;
	logic signed [50:0] prod_q;
	logic [2:0] st_q;
	logic [4:0] pend_nxt;

	div_req_t dreq;
	div_rsp_t drsp;

	kfli_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign pend_nxt = (pend_q < 5'd31) ? pend_q + 5'd1 : pend_q;

	// Write ports: add item stores coordinate and, at an accepted frame end, the time stamp.
	always_comb begin
		c_we    = 1'b0;
		c_waddr = {count_q[FrameAw-1:0], pend_q[DofAw-1:0]};
		c_wdata = value;
		if (state_q == S_IDLE && start && !busy && op == OP_ADD &&
		    pend_q < 5'(MaxDof) && count_q < CountW'(MaxFrames))
			c_we = 1'b1;
		t_we    = (state_q == S_ADDFIN) && (st_q == ST_OK);
		t_waddr = count_q[FrameAw-1:0];
		t_wdata = ptime_q;
	end

	// Read addresses
	always_comb begin
		t_raddr = idx_q;
		c_raddr = {seg_q, ci_q[DofAw-1:0]};
		case (state_q)
			S_RDA:    c_raddr = {seg_q, ci_q[DofAw-1:0]};
			S_RDB:    c_raddr = {seg_q + FrameAw'(1), ci_q[DofAw-1:0]};
			S_LASTRD: c_raddr = {seg_q, ci_q[DofAw-1:0]};
			default:  c_raddr = {seg_q, ci_q[DofAw-1:0]};
		endcase
	end

	// span = next - t0 where next is the read-back time
	always_comb begin
		dreq.start = (state_q == S_SRCH_CMP) && (idx_q != '0) &&
			(t0_q <= qt_q) && (qt_q < t_rdata_q);
		dreq.num = qt_q - t0_q;
		dreq.den = t_rdata_q - t0_q;
	end

	logic signed [32:0] bsx;
	logic signed [50:0] mulv;
	logic signed [32:0] res;
	assign bsx  = {c_rdata_q[31], c_rdata_q};
	assign mulv = diffv_q * $signed({1'b0, frac_q});
	// arithmetic shift floors toward minus infinity
	assign res  = a_q + 33'(prod_q >>> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dof_q   <= 5'd1;
			count_q <= '0;
			pend_q  <= '0;
			ptime_q <= '0;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						dof_q   <= cfg_data;
						count_q <= '0;
						pend_q  <= '0;
						ptime_q <= '0;
					end else if (start) begin
						qt_q <= time_req;
						if (op == OP_ADD) begin
							if (pend_q == 5'd0) ptime_q <= time_req;
							pend_q <= pend_nxt;
							if (frame_end) state_q <= S_ADDCHK;
						end else if (count_q == '0) begin
							status <= ST_EMPTY; coord_index <= '0; result_value <= '0;
							last <= 1'b1; strobe <= 1'b1;
						end else begin
							idx_q   <= '0;
							n_q     <= (dof_q > 5'(MaxDof)) ? 5'(MaxDof) : dof_q;
							state_q <= S_SRCH_RD;
						end
					end
				end
				S_ADDCHK: begin
					if (pend_q != dof_q || pend_q > 5'(MaxDof)) st_q <= ST_DOF;
					else if (count_q != '0 && ptime_q < lastt_q) st_q <= ST_ORDER;
					else if (count_q >= CountW'(MaxFrames)) st_q <= ST_FULL;
					else st_q <= ST_OK;
					state_q <= S_ADDFIN;
				end
				S_ADDFIN: begin
					if (st_q == ST_OK) begin
						count_q <= count_q + CountW'(1);
						lastt_q <= ptime_q;
					end
					pend_q <= '0;
					status <= st_q; coord_index <= '0; result_value <= '0;
					last <= 1'b1; strobe <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SRCH_RD: state_q <= S_SRCH_CMP;
				S_SRCH_CMP: begin
					if (dreq.start) begin
						seg_q   <= idx_q - FrameAw'(1);
						state_q <= S_DIV;
					end else if (CountW'(idx_q) + CountW'(1) >= count_q) begin
						seg_q   <= count_q[FrameAw-1:0] - FrameAw'(1);
						ci_q    <= '0;
						frac_q  <= '0;
						state_q <= S_LASTRD;
					end else begin
						t0_q    <= t_rdata_q;
						idx_q   <= idx_q + FrameAw'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_DIV: if (drsp.done) begin
					frac_q  <= drsp.quot;
					ci_q    <= '0;
					state_q <= S_RDA;
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: begin
					a_q     <= bsx;
					state_q <= S_MUL;
				end
				S_MUL: begin
					diffv_q <= bsx - a_q;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					prod_q <= mulv;
					state_q <= S_LASTEMIT;
				end
				S_LASTEMIT: begin
					status <= ST_OK; coord_index <= ci_q[3:0];
					result_value <= res[31:0];
					last <= (ci_q + 5'd1 == n_q); strobe <= 1'b1;
					ci_q <= ci_q + 5'd1;
					if (ci_q + 5'd1 == n_q) state_q <= S_IDLE;
					else state_q <= S_RDA;
				end
				S_LASTRD: begin
					// frame row read: the registered read is emitted in the next cycle; frac bit 16 is the phase
					frac_q[16] <= 1'b1;
					if (frac_q[16]) begin
						status <= ST_OK; coord_index <= ci_q[3:0];
						result_value <= c_rdata_q;
						last <= (ci_q + 5'd1 == n_q); strobe <= 1'b1;
						ci_q <= ci_q + 5'd1;
						frac_q[16] <= 1'b0;
						if (ci_q + 5'd1 == n_q) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_strobe_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> state_q == S_IDLE) else $error("last result while busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(MaxFrames)) else $error("frame count overflow");
	a_div_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == S_DIV) else $error("stray divide result");
`endif
endmodule
`default_nettype wire

// ===== verif/keyframe_linear_interpolator_top_test.sv =====
`default_nettype none
module keyframe_linear_interpolator_top_test;
	import kfli_pkg::*;

	localparam int CycleLimit = 3000000;
	localparam int DrainCycles = 700;   // longer than the worst-case query

	// one expected output beat
	typedef struct {
		status_t     st;
		logic [3:0]  idx;
		logic [31:0] val;
		logic        lst;
	} beat_t;

	// directed stimulus row; has_exp marks a status typed in by hand
	typedef struct {
		logic        op;
		logic [31:0] t;
		logic [31:0] v;
		logic        fend;
		bit          has_exp;
		status_t     exp_st;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic op = OP_ADD;
	logic [31:0] time_req = '0;
	logic signed [31:0] value = '0;
	logic frame_end = 1'b0;
	logic cfg_valid = 1'b0;
	logic [4:0] cfg_data = '0;
	logic busy, cfg_ready, strobe, last;
	logic [2:0] status;
	logic [3:0] coord_index;
	logic signed [31:0] result_value;

	keyframe_linear_interpolator_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .time_req(time_req), .value(value), .frame_end(frame_end),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.strobe(strobe), .status(status), .coord_index(coord_index),
		.result_value(result_value), .last(last)
	);

	always #2 clk = ~clk;

	// shadow copy of the keyframe table
	logic [31:0] key_times [MaxFrames];
	logic [31:0] key_coords [MaxFrames*MaxDof];
	int unsigned key_count, part_count, dofs;
	logic [31:0] part_time;

	beat_t pending_beats[$];
	int errors = 0;
	int cycles = 0;
	int n_items = 0, n_queries = 0, n_beats = 0, n_hits = 0;
	int n_status [8];

	// append one beat to the expected queue
	function automatic void expect_beat(beat_t b);
		pending_beats.insert(pending_beats.size(), b);
	endfunction

	// Expected beats for one accepted transaction; keep=0 updates state only.
	function automatic void predict_item(logic o, logic [31:0] t, logic [31:0] v, logic fe,
			bit keep);
		beat_t b;
		int unsigned c, n, seg;
		longint signed a, bb, frac, p;
		longint unsigned num, span;
		status_t st;
		if (o == OP_ADD) begin
			c = part_count;
			if (c == 0) part_time = t;
			if (c < MaxDof && key_count < MaxFrames) key_coords[key_count*MaxDof + c] = v;
			if (c < 31) part_count = c + 1;
			if (!fe) return;
			if (part_count != dofs || part_count > MaxDof) st = ST_DOF;
			else if (key_count > 0 && part_time < key_times[key_count-1]) st = ST_ORDER;
			else if (key_count >= MaxFrames) st = ST_FULL;
			else begin
				key_times[key_count] = part_time;
				key_count++;
				st = ST_OK;
			end
			part_count = 0;
			b = '{st, 4'd0, 32'd0, 1'b1};
			if (keep) expect_beat(b);
			return;
		end
		if (key_count == 0) begin
			b = '{ST_EMPTY, 4'd0, 32'd0, 1'b1};
			if (keep) expect_beat(b);
			return;
		end
		n = (dofs > MaxDof) ? MaxDof : dofs;
		seg = key_count;
		for (int i = 0; i + 1 < key_count; i++) begin
			if (key_times[i] <= t && t < key_times[i+1]) begin
				seg = i;
				break;
			end
		end
		if (seg != key_count) n_hits++;
		for (int i = 0; i < n; i++) begin
			if (seg == key_count) begin
				b.val = key_coords[(key_count-1)*MaxDof + i];
			end else begin
				num = longint'(t - key_times[seg]) << 16;
				span = longint'(key_times[seg+1] - key_times[seg]);
				frac = num / span;
				a = longint'(signed'(key_coords[seg*MaxDof + i]));
				bb = longint'(signed'(key_coords[(seg+1)*MaxDof + i]));
				p = (bb - a) * frac;
				p = a + (p >>> 16);   // arithmetic shift floors
				b.val = p[31:0];
			end
			b.st = ST_OK;
			b.idx = i[3:0];
			b.lst = (i + 1 == n);
			if (keep) expect_beat(b);
		end
	endfunction

	// output checker: strobed beats cannot be held off
	always @(posedge clk) begin
		beat_t b;
		if (arst_n && strobe) begin
			n_beats++;
			if (pending_beats.size() == 0) begin
				$error("unexpected result: status=%0d idx=%0d value=%h", status, coord_index,
					result_value);
				errors++;
			end else begin
				b = pending_beats.pop_front();
				n_status[status]++;
				if (status !== b.st) begin
					$error("status: expected %0d, got %0d", b.st, status);
					errors++;
				end
				if (coord_index !== b.idx) begin
					$error("coord_index: expected %0d, got %0d", b.idx, coord_index);
					errors++;
				end
				if (result_value !== b.val) begin
					$error("result_value: expected %h, got %h", b.val, result_value);
					errors++;
				end
				if (last !== b.lst) begin
					$error("last: expected %0d, got %0d", b.lst, last);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Drive one transaction and hold it until the edge that accepts it.
	// start stays high; the caller drops it only when a gap follows.
	task automatic issue(logic o, logic [31:0] t, logic [31:0] v, logic fe, bit keep);
		start <= 1'b1;
		op <= o;
		time_req <= t;
		value <= v;
		frame_end <= fe;
		do @(posedge clk); while (busy);
		predict_item(o, t, v, fe, keep);
		n_items++;
		if (o == OP_QUERY) n_queries++;
	endtask

	// sender burst/gap pattern
	int burst_left = 0;
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 12);
		if ($urandom_range(0, 2) != 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
	endtask

	// config writes only with the block idle; inner coordinates leave no beat,
	// so allow the longest in-flight operation to finish too
	task automatic write_dofs(logic [4:0] d);
		drain();
		repeat (DrainCycles) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dofs = d;
		key_count = 0;
		part_count = 0;
		part_time = '0;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// well-formed keyframes with random content, some out of order or miscounted
	logic [31:0] t_cur;
	task automatic random_traffic(int n);
		int cnt;
		logic [31:0] qt;
		while (n > 0) begin
			if ($urandom_range(0, 2) == 0) begin
				if (key_count > 1 && $urandom_range(0, 3) != 0)
					qt = $urandom_range(key_times[0], key_times[key_count-1]);
				else if (key_count > 0 && $urandom_range(0, 1) == 0)
					qt = key_times[$urandom_range(0, key_count-1)];
				else
					qt = $urandom;
				issue(OP_QUERY, qt, $urandom, 1'($urandom_range(0, 1)), 1);
				pace();
				n--;
			end else begin
				case ($urandom_range(0, 9))
					0: t_cur = t_cur - $urandom_range(1, 5000);
					1: ;                        // repeat time stamp
					2: t_cur = t_cur + $urandom;
					default: t_cur = t_cur + $urandom_range(1, 1 << 20);
				endcase
				cnt = (dofs == 0) ? 1 : dofs;
				if ($urandom_range(0, 9) == 0) cnt = $urandom_range(1, 20);
				for (int i = 0; i < cnt; i++) begin
					// later coordinates' time is ignored, so randomize it
					issue(OP_ADD, (i == 0) ? t_cur : $urandom, rand_coord(), i == cnt - 1, 1);
					pace();
					n--;
				end
			end
			if ($urandom_range(0, 40) == 0) drain();
		end
	endtask

	row_t directed [] = '{
		'{OP_QUERY, 32'd0,          32'd0,          1'b0, 1, ST_EMPTY},
		'{OP_ADD,   32'd100,        32'h7fff_ffff,  1'b1, 1, ST_OK},
		'{OP_ADD,   32'd50,         32'd0,          1'b1, 1, ST_ORDER},
		'{OP_ADD,   32'd100,        32'h8000_0000,  1'b1, 1, ST_OK},   // equal time
		'{OP_ADD,   32'd300,        32'h0001_0000,  1'b0, 0, ST_OK},
		'{OP_ADD,   32'd0,          32'd5,          1'b1, 1, ST_DOF},  // two coords
		'{OP_QUERY, 32'd7,          32'hffff_ffff,  1'b1, 0, ST_OK},
		'{OP_ADD,   32'd300,        32'h0001_0000,  1'b1, 1, ST_OK},
		'{OP_QUERY, 32'd0,          32'd0,          1'b0, 0, ST_OK},   // before first
		'{OP_QUERY, 32'd100,        32'd0,          1'b0, 0, ST_OK},
		'{OP_QUERY, 32'd200,        32'd0,          1'b0, 0, ST_OK},
		'{OP_QUERY, 32'd299,        32'd0,          1'b0, 0, ST_OK},
		'{OP_QUERY, 32'd300,        32'd0,          1'b0, 0, ST_OK},   // at last
		'{OP_QUERY, 32'hffff_ffff,  32'd0,          1'b0, 0, ST_OK},
		'{OP_ADD,   32'hffff_ffff,  32'hffff_ffff,  1'b1, 1, ST_OK},
		'{OP_QUERY, 32'hffff_fffe,  32'd0,          1'b0, 0, ST_OK},
		'{OP_QUERY, 32'h8000_0000,  32'd0,          1'b0, 0, ST_OK}
	};

	initial begin
		beat_t b;
		dofs = 1;
		key_count = 0;
		part_count = 0;
		part_time = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: hand-typed statuses where obvious, predictor elsewhere
		foreach (directed[i]) begin
			issue(directed[i].op, directed[i].t, directed[i].v, directed[i].fend,
				!directed[i].has_exp);
			if (directed[i].has_exp) begin
				b = '{directed[i].exp_st, 4'd0, 32'd0, 1'b1};
				expect_beat(b);
			end
			pace();
		end

		// widest frames, then random traffic
		write_dofs(5'd16);
		t_cur = $urandom_range(0, 1 << 30);
		random_traffic(12);

		// unusable settings: nothing ever stores
		write_dofs(5'd0);
		issue(OP_ADD, $urandom, $urandom, 1'b1, 1);
		issue(OP_QUERY, $urandom, 32'd0, 1'b0, 1);
		write_dofs(5'd17);
		for (int i = 0; i < 17; i++) issue(OP_ADD, $urandom, $urandom, i == 16, 1);
		issue(OP_QUERY, $urandom, 32'd0, 1'b0, 1);

		// fill the table, then overflow it
		write_dofs(5'd1);
		t_cur = 32'd1000;
		for (int i = 0; i < MaxFrames + 1; i++) begin
			issue(OP_ADD, t_cur, rand_coord(), 1'b1, 1);
			t_cur = t_cur + $urandom_range(1, 100);
			pace();
		end
		issue(OP_QUERY, 32'd1000 + $urandom_range(0, 12000), 32'd0, 1'b0, 1);
		issue(OP_QUERY, t_cur, 32'd0, 1'b0, 1);

		// over-long keyframe saturates its count
		write_dofs(5'd2);
		for (int i = 0; i < 34; i++) issue(OP_ADD, 32'd5, rand_coord(), i == 33, 1);

		write_dofs(5'd3);
		t_cur = $urandom;
		t_cur[31] = 1'b0;
		random_traffic(16);

		// wait for the last beats, then let the block settle
		drain();
		repeat (DrainCycles) @(posedge clk);

		$display("%0d transactions (%0d queries, %0d interval hits), %0d results checked",
			n_items, n_queries, n_hits, n_beats);
		$display("status counts ok/dof/order/full/empty: %0d/%0d/%0d/%0d/%0d",
			n_status[0], n_status[1], n_status[2], n_status[3], n_status[4]);
		if (errors == 0 && pending_beats.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire
